// File: rtl/core/template_score_top_k_unit_assert.svh
// Assertion macros for the checker module of the template scoring unit.
`ifndef TEMPLATE_SCORE_TOP_K_UNIT_ASSERT_SVH
`define TEMPLATE_SCORE_TOP_K_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TSK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define TSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/tsk_pkg.sv
package tsk_pkg;

    // Field widths.
    localparam int TSK_ID_W     = 16;
    localparam int TSK_SAMPLE_W = 16;
    localparam int TSK_SUM_W    = 48;
    localparam int TSK_SCORE_W  = 48;
    localparam int TSK_RANK_W   = 3;
    localparam int TSK_MIN_W    = 12;
    localparam int TSK_RAMP_W   = 13;
    localparam int TSK_KEEP_W   = 4;

    // Configuration port geometry.
    localparam int TSK_PADDR_W = 4;
    localparam int TSK_PDATA_W = 32;

    // Default sizes of the block.
    localparam int TSK_MAX_KEEP_DEF   = 8;
    localparam int TSK_MAX_PIXELS_DEF = 4096;

    // Register reset values.
    localparam logic [TSK_MIN_W-1:0]  TSK_MIN_RST  = 12'd20;
    localparam logic [TSK_RAMP_W-1:0] TSK_RAMP_RST = 13'd80;
    localparam logic [TSK_KEEP_W-1:0] TSK_KEEP_RST = 4'd8;

    // Saturated score, also used as the penalty score.
    localparam logic [TSK_SCORE_W-1:0] TSK_SCORE_MAX = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;     // accumulate the accepted sample
        logic cap_en;     // capture id and set flag of a template end
        logic eval_en;    // classify the template and clear the accumulator
        logic div_load;   // start the score division
        logic ins_en;     // insert the score into the ranked list
        logic rep_start;  // rewind the report rank
        logic rep_load;   // load one report entry into the output register
        logic fill_clr;   // empty the ranked list
    } t_tsk_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;       // too few samples, template is dropped
        logic pen;        // exactly min_pixels samples
        logic div_busy;   // divider is iterating
        logic eos;        // the template that ended also ends the set
        logic out_free;   // output register can take a new result
        logic rank_last;  // current report rank is the final one
    } t_tsk_sts;

endpackage

// File: rtl/core/tsk_div.sv
module tsk_div import tsk_pkg::*; #(
    parameter int NUM_W = TSK_SUM_W + TSK_RAMP_W,
    parameter int DEN_W = 2 * TSK_RAMP_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    // One restoring step per cycle, numerator bits enter from the top.
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The numerator shifts out while the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= DEN_W'(w_trial);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: rtl/core/tsk_dp.sv
module tsk_dp import tsk_pkg::*; #(
    parameter int MAX_KEEP   = TSK_MAX_KEEP_DEF,
    parameter int MAX_PIXELS = TSK_MAX_PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_tsk_cmd                       i_cmd,
    output t_tsk_sts                       o_sts,
    input  logic [TSK_ID_W-1:0]            i_template_id,
    input  logic signed [TSK_SAMPLE_W-1:0] i_sample,
    input  logic                           i_end_of_set,
    input  logic [TSK_MIN_W-1:0]           i_min_pixels,
    input  logic [TSK_RAMP_W-1:0]          i_ramp_pixels,
    input  logic [TSK_KEEP_W-1:0]          i_keep_count,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [TSK_RANK_W-1:0]          o_rank,
    output logic [TSK_ID_W-1:0]            o_best_template,
    output logic [TSK_SCORE_W-1:0]         o_score,
    output logic                           o_entry_valid,
    output logic                           o_last
);

    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int NW    = (CW > TSK_RAMP_W) ? CW : TSK_RAMP_W;
    localparam int NUM_W = TSK_SUM_W + TSK_RAMP_W;
    localparam int DEN_W = 2 * NW;
    localparam int KW    = $clog2(MAX_KEEP + 1);
    localparam int IW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int SQ_W  = 2 * TSK_SAMPLE_W;

    // Accumulator and captured template data.
    logic [TSK_SUM_W-1:0]   r_sum;
    logic [CW-1:0]          r_cnt;
    logic [TSK_ID_W-1:0]    r_tid;
    logic                   r_eos;
    logic                   r_pen;

    // Ranked list and report state.
    logic [TSK_SCORE_W-1:0] r_scores [MAX_KEEP];
    logic [TSK_ID_W-1:0]    r_ids    [MAX_KEEP];
    logic [KW-1:0]          r_filled;
    logic [IW-1:0]          r_rank;

    // Output register.
    logic                   r_out_valid;
    logic [TSK_RANK_W-1:0]  r_out_rank;
    logic [TSK_ID_W-1:0]    r_out_id;
    logic [TSK_SCORE_W-1:0] r_out_score;
    logic                   r_out_ev;
    logic                   r_out_last;

    logic signed [SQ_W-1:0] w_sq;
    logic [TSK_SUM_W:0]     w_sum_ext;
    logic [TSK_SUM_W-1:0]   w_sum_sat;
    logic [NW-1:0]          w_n;
    logic [NW-1:0]          w_min;
    logic [NW-1:0]          w_ramp;
    logic                   w_ramp_case;
    logic [TSK_RAMP_W-1:0]  w_diff;
    logic [NUM_W-1:0]       w_num;
    logic [DEN_W-1:0]       w_den;
    logic [NUM_W-1:0]       w_quo;
    logic                   w_div_busy;
    logic [TSK_SCORE_W-1:0] w_score;
    logic [KW-1:0]          w_keep;
    logic [KW-1:0]          w_cut;
    logic [MAX_KEEP-1:0]    w_le;
    logic [MAX_KEEP-1:0]    w_lep;
    logic                   w_drop;
    logic [TSK_SCORE_W-1:0] w_sh_scores [MAX_KEEP];
    logic [TSK_ID_W-1:0]    w_sh_ids    [MAX_KEEP];
    logic                   w_rd_valid;
    logic                   w_rank_last;
    logic                   w_out_free;

    // Square of the sample, added with saturation.
    assign w_sq      = i_sample * i_sample;
    assign w_sum_ext = {1'b0, r_sum} + (TSK_SUM_W + 1)'($unsigned(w_sq));
    assign w_sum_sat = w_sum_ext[TSK_SUM_W] ? TSK_SCORE_MAX : w_sum_ext[TSK_SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.eval_en) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc_en && (r_cnt < CW'(MAX_PIXELS))) begin
            r_sum <= w_sum_sat;
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // Capture of the template end and of the penalty decision.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_tid <= i_template_id;
            r_eos <= i_end_of_set;
        end
        if (i_cmd.eval_en) begin
            r_pen <= o_sts.pen;
        end
    end

    // Classification and the operands of the score division.
    assign w_n         = NW'(r_cnt);
    assign w_min       = NW'(i_min_pixels);
    assign w_ramp      = NW'(i_ramp_pixels);
    assign w_ramp_case = w_n < w_ramp;
    assign w_diff      = i_ramp_pixels - TSK_RAMP_W'(i_min_pixels);

    always_comb begin
        if (w_ramp_case) begin
            w_num = NUM_W'(r_sum) * NUM_W'(w_diff);
            w_den = DEN_W'(w_n) * DEN_W'(w_n - w_min);
        end else begin
            w_num = NUM_W'(r_sum);
            w_den = DEN_W'(w_n);
        end
    end

    tsk_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.div_load),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Final score: the penalty score if penalized, else the quotient with saturation.
    always_comb begin
        if (r_pen || (|w_quo[NUM_W-1:TSK_SCORE_W])) begin
            w_score = TSK_SCORE_MAX;
        end else begin
            w_score = w_quo[TSK_SCORE_W-1:0];
        end
    end

    // Effective keep count: zero acts as one, large values clamp.
    always_comb begin
        if (i_keep_count == '0) begin
            w_keep = KW'(1);
        end else if (32'(i_keep_count) > 32'(MAX_KEEP)) begin
            w_keep = KW'(MAX_KEEP);
        end else begin
            w_keep = KW'(i_keep_count);
        end
    end

    assign w_cut = (r_filled < w_keep) ? r_filled : w_keep;

    // Each list cell compares itself with the new score; the held entries
    // that are not worse form a prefix, and the new score goes right behind it.
    always_comb begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            w_le[i] = (KW'(i) < w_cut) && (r_scores[i] <= w_score);
        end
        w_lep[0] = 1'b1;
        for (int i = 1; i < MAX_KEEP; i++) begin
            w_lep[i] = w_le[i-1];
        end
        w_sh_scores[0] = r_scores[0];
        w_sh_ids[0]    = r_ids[0];
        for (int i = 1; i < MAX_KEEP; i++) begin
            w_sh_scores[i] = r_scores[i-1];
            w_sh_ids[i]    = r_ids[i-1];
        end
    end

    assign w_drop = w_le[IW'(w_keep - KW'(1))];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en && !w_drop) begin
            for (int i = 0; i < MAX_KEEP; i++) begin
                if (!w_le[i]) begin
                    if (w_lep[i]) begin
                        r_scores[i] <= w_score;
                        r_ids[i]    <= r_tid;
                    end else begin
                        r_scores[i] <= w_sh_scores[i];
                        r_ids[i]    <= w_sh_ids[i];
                    end
                end
            end
        end
    end

    // Fill count: cut to the keep count, then grow by one if there was room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_cmd.fill_clr) begin
            r_filled <= '0;
        end else if (i_cmd.ins_en) begin
            r_filled <= (w_cut < w_keep) ? w_cut + KW'(1) : w_cut;
        end
    end

    // Report sequencing, one rank per loaded result.
    assign w_rd_valid  = KW'(r_rank) < r_filled;
    assign w_rank_last = (KW'(r_rank) + KW'(1)) == w_keep;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (i_cmd.rep_start) begin
            r_rank <= '0;
        end else if (i_cmd.rep_load && !w_rank_last) begin
            r_rank <= r_rank + IW'(1);
        end
    end

    // Output register, so a waiting result does not hold up the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rep_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_load) begin
            r_out_rank  <= TSK_RANK_W'(r_rank);
            r_out_id    <= w_rd_valid ? r_ids[r_rank] : '0;
            r_out_score <= w_rd_valid ? r_scores[r_rank] : '0;
            r_out_ev    <= w_rd_valid;
            r_out_last  <= w_rank_last;
        end
    end

    // Status to the controller.
    assign o_sts.skip      = w_n < w_min;
    assign o_sts.pen       = w_n == w_min;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.eos       = r_eos;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.rank_last = w_rank_last;

    assign o_out_valid     = r_out_valid;
    assign o_rank          = r_out_rank;
    assign o_best_template = r_out_id;
    assign o_score         = r_out_score;
    assign o_entry_valid   = r_out_ev;
    assign o_last          = r_out_last;

endmodule

// File: rtl/core/tsk_ctrl.sv
module tsk_ctrl import tsk_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_end_of_template,
    input  t_tsk_sts i_sts,
    output logic     o_in_stall,
    output t_tsk_cmd o_cmd
);

    localparam logic [2:0] S_ACCEPT = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_stall = r_state != S_ACCEPT;
    assign w_accept   = i_in_valid && (r_state == S_ACCEPT);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_ACCEPT: begin
                o_cmd.acc_en = w_accept;
                o_cmd.cap_en = w_accept && i_end_of_template;
                if (w_accept && i_end_of_template) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval_en = 1'b1;
                if (i_sts.skip) begin
                    if (i_sts.eos) begin
                        o_cmd.rep_start = 1'b1;
                        n_state         = S_REPORT;
                    end else begin
                        n_state = S_ACCEPT;
                    end
                end else if (i_sts.pen) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.ins_en = 1'b1;
                if (i_sts.eos) begin
                    o_cmd.rep_start = 1'b1;
                    n_state         = S_REPORT;
                end else begin
                    n_state = S_ACCEPT;
                end
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.rep_load = 1'b1;
                    if (i_sts.rank_last) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = S_ACCEPT;
                    end
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/template_score_top_k_unit.sv
// Template scoring unit: takes one distance sample request per cycle, sums the
// squares per template and, at the end of each template, forms a mean squared
// score that is ranked into a sorted list of the best keep_count templates; the
// end of a set reports that list, best first, one result per cycle while the
// output is not stalled, and empties it. Samples inside a template are taken
// back to back. After the last sample of a template the input is stalled while
// the score is formed: a skipped template is only classified, a penalized one
// is classified and inserted, and any other one is classified, then divided
// by the bit-serial divider that produces one quotient bit per cycle, seen to
// finish and inserted into the list in parallel. A set end then also stalls
// the input while keep_count results go out. Configuration must be written
// through the register port while the unit is idle; this is not enforced.
module template_score_top_k_unit import tsk_pkg::*; #(
    parameter int MAX_KEEP   = TSK_MAX_KEEP_DEF,
    parameter int MAX_PIXELS = TSK_MAX_PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample requests.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [TSK_ID_W-1:0]            i_template_id,
    input  logic signed [TSK_SAMPLE_W-1:0] i_sample,
    input  logic                           i_end_of_template,
    input  logic                           i_end_of_set,
    // Ranked results.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [TSK_RANK_W-1:0]          o_rank,
    output logic [TSK_ID_W-1:0]            o_best_template,
    output logic [TSK_SCORE_W-1:0]         o_score,
    output logic                           o_entry_valid,
    output logic                           o_last,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [TSK_PADDR_W-1:0]         paddr,
    input  logic [TSK_PDATA_W-1:0]         pwdata,
    output logic [TSK_PDATA_W-1:0]         prdata,
    output logic                           pready
);

    localparam logic [1:0] REG_MIN  = 2'd0;
    localparam logic [1:0] REG_RAMP = 2'd1;
    localparam logic [1:0] REG_KEEP = 2'd2;

    logic [TSK_MIN_W-1:0]  r_min_pixels;
    logic [TSK_RAMP_W-1:0] r_ramp_pixels;
    logic [TSK_KEEP_W-1:0] r_keep_count;
    logic [1:0]            w_reg_idx;
    logic                  w_wr;
    t_tsk_cmd              w_cmd;
    t_tsk_sts              w_sts;

    // Register writes complete in the access phase; no wait states.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pixels  <= TSK_MIN_RST;
            r_ramp_pixels <= TSK_RAMP_RST;
            r_keep_count  <= TSK_KEEP_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_MIN:  r_min_pixels  <= pwdata[TSK_MIN_W-1:0];
                REG_RAMP: r_ramp_pixels <= pwdata[TSK_RAMP_W-1:0];
                REG_KEEP: r_keep_count  <= pwdata[TSK_KEEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back of the registers.
    always_comb begin
        case (w_reg_idx)
            REG_MIN:  prdata = TSK_PDATA_W'(r_min_pixels);
            REG_RAMP: prdata = TSK_PDATA_W'(r_ramp_pixels);
            REG_KEEP: prdata = TSK_PDATA_W'(r_keep_count);
            default:  prdata = '0;
        endcase
    end

    tsk_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_end_of_template (i_end_of_template),
        .i_sts             (w_sts),
        .o_in_stall        (o_in_stall),
        .o_cmd             (w_cmd)
    );

    tsk_dp #(
        .MAX_KEEP   (MAX_KEEP),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_template_id   (i_template_id),
        .i_sample        (i_sample),
        .i_end_of_set    (i_end_of_set),
        .i_min_pixels    (r_min_pixels),
        .i_ramp_pixels   (r_ramp_pixels),
        .i_keep_count    (r_keep_count),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_rank          (o_rank),
        .o_best_template (o_best_template),
        .o_score         (o_score),
        .o_entry_valid   (o_entry_valid),
        .o_last          (o_last)
    );

endmodule

// File: rtl/core/tsk_checker.sv
`include "template_score_top_k_unit_assert.svh"

module tsk_checker import tsk_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_stall,
    input logic                   i_out_valid,
    input logic                   i_out_stall,
    input logic [TSK_RANK_W-1:0]  i_rank,
    input logic [TSK_ID_W-1:0]    i_best_template,
    input logic [TSK_SCORE_W-1:0] i_score,
    input logic                   i_entry_valid,
    input logic                   i_last
);

    logic [TSK_RANK_W-1:0] r_prev_rank;
    logic                  w_out_take;
    logic                  w_empty_ok;
    logic                  w_rank_step;

    // Rank shown in the previous cycle, for the rank sequence check.
    always_ff @(posedge i_clk) begin
        r_prev_rank <= i_rank;
    end

    assign w_out_take  = i_out_valid && !i_out_stall;
    assign w_empty_ok  = (i_score == '0) && (i_best_template == '0);
    assign w_rank_step = i_rank == TSK_RANK_W'(r_prev_rank + TSK_RANK_W'(1));

    // A stalled result stays offered.
    `TSK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)

    // An empty rank reports zero id and zero score.
    `TSK_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_entry_valid, w_empty_ok)

    // While a report is still running, no new sample request is taken.
    `TSK_ASSERT_NOW(a_report_stalls_input, i_clk, i_rst_n, i_out_valid && !i_last, i_in_stall)

    // Inside a report the ranks follow each other without gaps.
    `TSK_ASSERT_NEXT(a_rank_step, i_clk, i_rst_n, w_out_take && !i_last, i_out_valid && w_rank_step)

endmodule

bind template_score_top_k_unit tsk_checker u_tsk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_stall      (o_in_stall),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_rank          (o_rank),
    .i_best_template (o_best_template),
    .i_score         (o_score),
    .i_entry_valid   (o_entry_valid),
    .i_last          (o_last)
);

// File: tb/template_score_top_k_checker.sv
module template_score_top_k_checker import tsk_pkg::*; #(
    parameter int MAX_KEEP   = TSK_MAX_KEEP_DEF,
    parameter int MAX_PIXELS = TSK_MAX_PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample request channel, observed only.
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [TSK_ID_W-1:0]            i_template_id,
    input  logic signed [TSK_SAMPLE_W-1:0] i_sample,
    input  logic                           i_end_of_template,
    input  logic                           i_end_of_set,
    // Ranked result channel, observed only.
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [TSK_RANK_W-1:0]          i_rank,
    input  logic [TSK_ID_W-1:0]            i_best_template,
    input  logic [TSK_SCORE_W-1:0]         i_score,
    input  logic                           i_entry_valid,
    input  logic                           i_last,
    // Register values currently programmed into the block.
    input  logic [TSK_MIN_W-1:0]           i_min_pixels,
    input  logic [TSK_RAMP_W-1:0]          i_ramp_pixels,
    input  logic [TSK_KEEP_W-1:0]          i_keep_count,
    output int                             o_pending,
    output int                             o_fail_count
);

    typedef struct packed {
        logic [TSK_RANK_W-1:0]  rank;
        logic [TSK_ID_W-1:0]    best_template;
        logic [TSK_SCORE_W-1:0] score;
        logic                   entry_valid;
        logic                   last;
    } t_rank_report;

    // Shadow of the accumulator and of the ranked list.
    logic [TSK_SUM_W-1:0]   square_total;
    int unsigned            sample_count;
    logic [TSK_SCORE_W-1:0] kept_score [MAX_KEEP];
    logic [TSK_ID_W-1:0]    kept_id [MAX_KEEP];
    int unsigned            kept_len;
    t_rank_report           expected_reports [$];
    int                     mismatches = 0;

    // Keep count as the block applies it: zero acts as one, large values clamp.
    function automatic int unsigned keep_limit();
        if (i_keep_count == '0) return 1;
        if (int'(i_keep_count) > MAX_KEEP) return MAX_KEEP;
        return i_keep_count;
    endfunction

    // Accumulate one accepted sample request and, at a template end, score and rank it.
    task automatic accept_sample(input logic [TSK_ID_W-1:0] id,
                                 input logic signed [TSK_SAMPLE_W-1:0] smp,
                                 input logic eot, input logic eos);
        logic signed [31:0] sq;
        logic [63:0]        total;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        sc;
        int unsigned        k;
        int unsigned        held;
        int unsigned        pos;
        int unsigned        i;
        int unsigned        n;
        bit                 ranked;
        t_rank_report       rep;

        sq = smp * smp;
        // Samples past the pixel limit are dropped; the end marks still act.
        if (sample_count < MAX_PIXELS) begin
            total = 64'(square_total) + 64'(unsigned'(sq));
            square_total = (total > 64'(TSK_SCORE_MAX)) ? TSK_SCORE_MAX
                                                        : total[TSK_SUM_W-1:0];
            sample_count++;
        end
        if (!eot) return;

        // Score: skipped, penalized, ramped for small templates, or plain mean.
        n = sample_count;
        ranked = 1'b1;
        sc = '0;
        if (n < i_min_pixels) begin
            ranked = 1'b0;
        end else if (n == i_min_pixels) begin
            sc = 64'(TSK_SCORE_MAX);
        end else if (n < i_ramp_pixels) begin
            num = 64'(square_total) * (64'(i_ramp_pixels) - 64'(i_min_pixels));
            den = 64'(n) * (64'(n) - 64'(i_min_pixels));
            sc = num / den;
        end else begin
            sc = 64'(square_total) / 64'(n);
        end
        if (sc > 64'(TSK_SCORE_MAX)) sc = 64'(TSK_SCORE_MAX);

        // Sorted insertion behind equal scores; the list is first cut to keep_count.
        if (ranked) begin
            k = keep_limit();
            held = (kept_len < k) ? kept_len : k;
            pos = 0;
            while (pos < held && kept_score[pos] <= sc[TSK_SCORE_W-1:0]) pos++;
            kept_len = held;
            if (pos < k) begin
                i = (held < k) ? held : k - 1;
                while (i > pos) begin
                    kept_score[i] = kept_score[i-1];
                    kept_id[i] = kept_id[i-1];
                    i--;
                end
                kept_score[pos] = sc[TSK_SCORE_W-1:0];
                kept_id[pos] = id;
                if (held < k) kept_len = held + 1;
            end
        end
        square_total = '0;
        sample_count = 0;
        if (!eos) return;

        // A set end reports keep_count ranks, then empties the list.
        k = keep_limit();
        for (int r = 0; r < k; r++) begin
            rep.rank = r[TSK_RANK_W-1:0];
            rep.entry_valid = (r < kept_len);
            rep.best_template = rep.entry_valid ? kept_id[r] : '0;
            rep.score = rep.entry_valid ? kept_score[r] : '0;
            rep.last = (r == k - 1);
            expected_reports.insert(expected_reports.size(), rep);
        end
        kept_len = 0;
    endtask

    // Compare one accepted result against the oldest expectation.
    task automatic check_report();
        t_rank_report want;
        bit           bad;

        if (expected_reports.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: rank=%0d id=%h score=%h valid=%b last=%b",
                         i_rank, i_best_template, i_score, i_entry_valid, i_last);
            mismatches++;
        end else begin
            want = expected_reports.pop_front();
            bad = (i_rank !== want.rank) || (i_best_template !== want.best_template) ||
                  (i_score !== want.score) || (i_entry_valid !== want.entry_valid) ||
                  (i_last !== want.last);
            if (bad) begin
                if (mismatches < 10) begin
                    $display("result mismatch: expected rank=%0d id=%h score=%h valid=%b last=%b",
                             want.rank, want.best_template, want.score, want.entry_valid,
                             want.last);
                    $display("                 actual   rank=%0d id=%h score=%h valid=%b last=%b",
                             i_rank, i_best_template, i_score, i_entry_valid, i_last);
                end
                mismatches++;
            end
        end
    endtask

    // Results are checked before the request of the same edge is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            square_total = '0;
            sample_count = 0;
            kept_len = 0;
            expected_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_report();
            if (i_in_valid && !i_in_stall)
                accept_sample(i_template_id, i_sample, i_end_of_template, i_end_of_set);
        end
        o_pending <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb_template_score_top_k_unit.sv
module tb_template_score_top_k_unit;
    import tsk_pkg::*;

    localparam logic [TSK_PADDR_W-1:0] MIN_PIXELS_ADDR  = 4'd0;
    localparam logic [TSK_PADDR_W-1:0] RAMP_PIXELS_ADDR = 4'd4;
    localparam logic [TSK_PADDR_W-1:0] KEEP_COUNT_ADDR  = 4'd8;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           o_in_stall;
    logic [TSK_ID_W-1:0]            in_id = '0;
    logic signed [TSK_SAMPLE_W-1:0] in_sample = '0;
    logic                           in_eot = 1'b0;
    logic                           in_eos = 1'b0;

    logic                           o_out_valid;
    logic                           out_stall = 1'b0;
    logic [TSK_RANK_W-1:0]          o_rank;
    logic [TSK_ID_W-1:0]            o_best_template;
    logic [TSK_SCORE_W-1:0]         o_score;
    logic                           o_entry_valid;
    logic                           o_last;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [TSK_PADDR_W-1:0]         paddr = '0;
    logic [TSK_PDATA_W-1:0]         pwdata = '0;
    logic [TSK_PDATA_W-1:0]         prdata;
    logic                           pready;

    // Register values as last written, for the checker.
    logic [TSK_MIN_W-1:0]           cfg_min = TSK_MIN_RST;
    logic [TSK_RAMP_W-1:0]          cfg_ramp = TSK_RAMP_RST;
    logic [TSK_KEEP_W-1:0]          cfg_keep = TSK_KEEP_RST;

    int pending_reports;
    int score_fails;
    int regfile_errs = 0;
    int tx_max = 0;
    int rx_max = 0;
    int hold_reqs = 0;
    int holds_done = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    template_score_top_k_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_template_id     (in_id),
        .i_sample          (in_sample),
        .i_end_of_template (in_eot),
        .i_end_of_set      (in_eos),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_rank            (o_rank),
        .o_best_template   (o_best_template),
        .o_score           (o_score),
        .o_entry_valid     (o_entry_valid),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    template_score_top_k_checker score_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (o_in_stall),
        .i_template_id     (in_id),
        .i_sample          (in_sample),
        .i_end_of_template (in_eot),
        .i_end_of_set      (in_eos),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .i_rank            (o_rank),
        .i_best_template   (o_best_template),
        .i_score           (o_score),
        .i_entry_valid     (o_entry_valid),
        .i_last            (o_last),
        .i_min_pixels      (cfg_min),
        .i_ramp_pixels     (cfg_ramp),
        .i_keep_count      (cfg_keep),
        .o_pending         (pending_reports),
        .o_fail_count      (score_fails)
    );

    // Result side: a random stall after each accepted result, or a long hold on request.
    always @(posedge clk) begin : rx_side
        int unsigned wait_draw;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (holds_done != hold_reqs) begin
            holds_done <= holds_done + 1;
            out_stall <= 1'b1;
            stall_left <= HOLD_CYCLES;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) out_stall <= 1'b0;
        end else if (o_out_valid && !out_stall) begin
            wait_draw = $urandom_range(0, rx_max);
            if (wait_draw != 0) begin
                out_stall <= 1'b1;
                stall_left <= wait_draw;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || psel || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // One sample request after a random gap; returns at the edge that accepts it.
    task automatic send_sample(input logic [TSK_ID_W-1:0] id, input logic [15:0] s,
                               input logic eot, input logic eos);
        int unsigned gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_id <= id;
        in_sample <= s;
        in_eot <= eot;
        in_eos <= eos;
        do @(posedge clk); while (o_in_stall);
    endtask

    // Stop offering requests and wait until every expected result has been taken.
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0) @(posedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input logic [TSK_PADDR_W-1:0] addr, input logic [31:0] data);
        logic [31:0] mask;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (addr)
            MIN_PIXELS_ADDR: begin
                cfg_min <= data[TSK_MIN_W-1:0];
                mask = (32'd1 << TSK_MIN_W) - 1;
            end
            RAMP_PIXELS_ADDR: begin
                cfg_ramp <= data[TSK_RAMP_W-1:0];
                mask = (32'd1 << TSK_RAMP_W) - 1;
            end
            default: begin
                cfg_keep <= data[TSK_KEEP_W-1:0];
                mask = (32'd1 << TSK_KEEP_W) - 1;
            end
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (data & mask)) begin
            if (regfile_errs < 10)
                $display("register read back at %h: expected %h, got %h",
                         addr, data & mask, prdata & mask);
            regfile_errs++;
        end
        // Deselecting the port closes the transfer before the next one starts.
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // New register setting once the block has drained, plus idling for both sides.
    task automatic set_config(input int min_px, input int ramp_px, input int keep,
                              input int tx_idle, input int rx_idle);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(MIN_PIXELS_ADDR, 32'(min_px));
        write_reg(RAMP_PIXELS_ADDR, 32'(ramp_px));
        write_reg(KEEP_COUNT_ADDR, 32'(keep));
        tx_max = tx_idle;
        rx_max <= rx_idle;
    endtask

    // Random templates: mostly well formed, with stray ids and lone set ends mixed in.
    task automatic run_templates(input int n_items, input int len_max);
        int          sent;
        int          len;
        logic [15:0] tid;
        logic [15:0] s;
        logic        eos;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, len_max);
            tid = 16'($urandom);
            eos = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++) begin
                case ($urandom_range(0, 7))
                    0: s = 16'h8000;
                    1: s = 16'h7FFF;
                    2: s = 16'h0000;
                    3: s = 16'hFFFF;
                    4, 5: s = 16'($urandom_range(0, 2047));
                    default: s = 16'($urandom);
                endcase
                if (j == len - 1)
                    send_sample(tid, s, 1'b1, eos);
                else
                    send_sample(($urandom_range(0, 7) == 0) ? 16'($urandom) : tid, s,
                                1'b0, $urandom_range(0, 9) == 0);
            end
            sent += len;
            // Now and then the sender pauses until the report has drained.
            if (eos && $urandom_range(0, 7) == 0) wait_results();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: skip with a lone set end, penalty, ramp, plain mean, tie, full list.
        set_config(3, 6, 3, 16, 16);
        send_sample(16'h0000, 16'h7FFF, 1'b0, 1'b1);
        send_sample(16'h0000, 16'h8000, 1'b1, 1'b0);
        send_sample(16'hFFFF, 16'h8000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 16'h7FFF, 1'b0, 1'b0);
        send_sample(16'hFFFF, 16'h0100, 1'b1, 1'b0);
        send_sample(16'hAAAA, 16'h7FFF, 1'b0, 1'b0);
        send_sample(16'hAAAA, 16'h0000, 1'b0, 1'b0);
        send_sample(16'h5555, 16'hFFFF, 1'b0, 1'b0);
        send_sample(16'h1234, 16'h8000, 1'b1, 1'b0);
        for (int j = 0; j < 6; j++) send_sample(16'h0001, 16'h0001, j == 5, 1'b0);
        for (int j = 0; j < 6; j++) send_sample(16'h0002, 16'h0001, j == 5, 1'b0);
        for (int j = 0; j < 3; j++) send_sample(16'h5555, 16'h0000, j == 2, j == 2);

        // Random phases over a spread of register settings.
        set_config(1, 4, 5, 16, 16);
        run_templates(50, 7);
        set_config(2, 2, 0, 4, 0);
        run_templates(40, 5);
        set_config(4, 5, 15, 0, 0);
        run_templates(40, 8);
        // Leave the set open with a full list so the next keep_count cuts it.
        for (int t = 0; t < 4; t++)
            for (int j = 0; j < 5; j++)
                send_sample(16'(t + 16'h0100), 16'($urandom), j == 4, 1'b0);
        set_config(0, 8191, 2, 8, 8);
        run_templates(40, 6);

        // Back pressure: reports pile up behind a long receiver hold.
        set_config(1, 3, 8, 0, 16);
        hold_reqs <= hold_reqs + 1;
        for (int t = 0; t < 6; t++)
            for (int j = 0; j < 4; j++)
                send_sample(16'($urandom), 16'($urandom), j == 1 || j == 3, j == 3);
        wait_results();

        // A long template on a steep ramp, then a skipped one closing the set.
        set_config(40, 8191, 1, 2, 16);
        for (int j = 0; j < 48; j++)
            send_sample(16'h7777, 16'h8000, j == 47, 1'b0);
        for (int j = 0; j < 3; j++) send_sample(16'h3C3C, 16'($urandom), j == 2, j == 2);

        set_config(TSK_MIN_RST, TSK_RAMP_RST, TSK_KEEP_RST, 16, 16);
        run_templates(40, 30);
        set_config(3, 10, 5, 16, 16);
        run_templates(40, 12);
        for (int j = 0; j < 3; j++) send_sample(16'hC3C3, 16'($urandom), j == 2, j == 2);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (score_fails == 0 && regfile_errs == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
